### hw/rtl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types and constants of the gravity source-term corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TAG_BITS   = 20;
    localparam int ROUND_SH   = 2 * FRAC_BITS + 1;
    localparam int DCAP_W     = 34;
    localparam int DIV_STEPS  = 33;
    localparam int PRE_STAGES = 8;
    localparam int NST        = PRE_STAGES + DIV_STEPS + 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP  = 3'd0,
        CFG_GRAV_X     = 3'd1,
        CFG_GRAV_Y     = 3'd2,
        CFG_GRAV_Z     = 3'd3,
        CFG_CELL_GRAV  = 3'd4,
        CFG_THREE_DIM  = 3'd5
    } gsc_cfg_idx_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [30:0]      dt;
        logic [2:0][31:0] grav;
        logic             cell_grav;
        logic             three_dim;
    } gsc_cfg_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [30:0]         rho_new;
        logic [31:0]         rho_sum;
        logic [2:0][31:0]    gmag;
        logic [2:0]          gneg;
        logic [2:0][31:0]    mom;
        logic [31:0]         energy;
        logic                zero;
    } gsc_item_t;

endpackage

`default_nettype wire

### hw/rtl/gsc_front.sv
// ----------------------------------------------------------------------------
// gsc_front
// Accepts a cell, selects its gravity and flags zero density.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_front
    import gsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gsc_cfg_t            cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [TAG_BITS-1:0] cell_tag,
    input  wire logic [30:0]         rho_old,
    input  wire logic [30:0]         rho_new,
    input  wire logic [31:0]         mom_x_in,
    input  wire logic [31:0]         mom_y_in,
    input  wire logic [31:0]         mom_z_in,
    input  wire logic [31:0]         energy_in,
    input  wire logic [31:0]         field_grav_x,
    input  wire logic [31:0]         field_grav_y,
    input  wire logic [31:0]         field_grav_z,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gsc_item_t                out_item
);

    logic             valid_reg;
    gsc_item_t        item_reg;
    gsc_item_t        item_next;
    logic [2:0][31:0] g;
    logic [2:0][31:0] fld;

    assign fld = {field_grav_z, field_grav_y, field_grav_x};

    always_comb
    begin
        item_next         = '0;
        item_next.tag     = cell_tag;
        item_next.rho_new = rho_new;
        item_next.rho_sum = {1'b0, rho_old} + {1'b0, rho_new};
        item_next.mom     = {mom_z_in, mom_y_in, mom_x_in};
        item_next.energy  = energy_in;
        item_next.zero    = (rho_new == '0);
        for (int i = 0; i < 3; i++)
        begin
            g[i] = cfg.cell_grav ? fld[i] : cfg.grav[i];
            item_next.gneg[i] = g[i][31];
            item_next.gmag[i] = g[i][31] ? (32'd0 - g[i]) : g[i];
        end
        if (!cfg.three_dim)
        begin
            item_next.gmag[2] = '0;
            item_next.gneg[2] = 1'b0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gsc_queue.sv
// ----------------------------------------------------------------------------
// gsc_queue
// Short queue of classified cells between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_queue
    import gsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire gsc_item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output gsc_item_t      out_item
);

    gsc_item_t            ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gsc_back.sv
// ----------------------------------------------------------------------------
// gsc_back
// Momentum kick, kinetic-energy change and pipelined division per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_back
    import gsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [30:0]         dt,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gsc_item_t           in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [TAG_BITS-1:0]      cell_tag_out,
    output logic [31:0]              mom_x_out,
    output logic [31:0]              mom_y_out,
    output logic [31:0]              mom_z_out,
    output logic [31:0]              energy_out,
    output logic [1:0]               status
);

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [30:0]         rho_new;
        logic [31:0]         energy;
        logic                zero;
        logic [2:0][31:0]    mom;
        logic                sat;
    } kin_t;

    typedef struct packed {
        kin_t        kin;
        logic        dneg;
        logic        ovf;
        logic [31:0] den;
    } div_t;

    logic             en;
    logic [NST-1:0]   v_reg;

    gsc_item_t        s1_item_reg, s2_item_reg, s3_item_reg;
    logic [62:0]      s1_a_reg;
    logic [2:0][63:0] s2_plo_reg;
    logic [2:0][62:0] s2_phi_reg;
    logic [2:0][DCAP_W-1:0] s3_dcap_reg;
    logic [2:0][DCAP_W-1:0] dcap_next;
    kin_t             s4_kin_reg, s5_kin_reg, s6_kin_reg, s7_kin_reg, s8_kin_reg;
    kin_t             kin_next;
    logic [2:0][31:0] s4_mi_reg, s4_mo_reg;
    logic [2:0][31:0] mi_next, mo_next;
    logic [2:0][63:0] s5_sqo_reg, s5_sqn_reg;
    logic [63:0]      s6_so_reg, s6_sn_reg;
    logic             s7_dneg_reg, s8_dneg_reg;
    logic [63:0]      s7_dmag_reg;
    logic [64:0]      s8_num_reg;

    div_t             dv_pl_reg  [DIV_STEPS+1];
    logic [31:0]      dv_rem_reg [DIV_STEPS+1];
    logic [32:0]      dv_num_reg [DIV_STEPS+1];
    logic [32:0]      dv_q_reg   [DIV_STEPS+1];
    logic [31:0]      rem_next   [DIV_STEPS];
    logic             qbit_next  [DIV_STEPS];

    div_t             fin;
    logic [35:0]      e_sum;
    logic [DCAP_W-1:0] de;
    logic [31:0]      e_next;
    logic             e_sat;

    logic [TAG_BITS-1:0] tag_reg;
    logic [2:0][31:0]    mom_reg;
    logic [31:0]         energy_reg;
    logic [1:0]          status_reg;

    assign en        = !v_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[NST-1];

    always_comb
    begin
        logic [94:0] full;
        logic [94:0] dlt;
        for (int i = 0; i < 3; i++)
        begin
            full = {s2_phi_reg[i], 32'd0} + 95'(s2_plo_reg[i])
                 + (95'd1 << (ROUND_SH - 1));
            dlt  = full >> ROUND_SH;
            dcap_next[i] = (|dlt[94:DCAP_W-1]) ? (DCAP_W'(1) << (DCAP_W - 1))
                                               : dlt[DCAP_W-1:0];
        end
    end

    always_comb
    begin
        logic [34:0] s;
        logic [34:0] d;
        kin_next         = '0;
        kin_next.tag     = s3_item_reg.tag;
        kin_next.rho_new = s3_item_reg.rho_new;
        kin_next.energy  = s3_item_reg.energy;
        kin_next.zero    = s3_item_reg.zero;
        for (int i = 0; i < 3; i++)
        begin
            d = {1'b0, s3_dcap_reg[i]};
            if (s3_item_reg.gneg[i])
            begin
                d = 35'd0 - d;
            end
            s = {{3{s3_item_reg.mom[i][31]}}, s3_item_reg.mom[i]} + d;
            if (s3_item_reg.zero)
            begin
                kin_next.mom[i] = s3_item_reg.mom[i];
            end
            else if (s[34:31] != 4'b0000 && s[34:31] != 4'b1111)
            begin
                kin_next.mom[i] = s[34] ? 32'h8000_0000 : 32'h7fff_ffff;
                kin_next.sat    = 1'b1;
            end
            else
            begin
                kin_next.mom[i] = s[31:0];
            end
            mi_next[i] = s3_item_reg.mom[i][31] ? (32'd0 - s3_item_reg.mom[i])
                                                : s3_item_reg.mom[i];
            mo_next[i] = kin_next.mom[i][31] ? (32'd0 - kin_next.mom[i])
                                             : kin_next.mom[i];
        end
    end

    always_comb
    begin
        logic [32:0] t;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            t = {dv_rem_reg[k], dv_num_reg[k][32]};
            qbit_next[k] = (t >= {1'b0, dv_pl_reg[k].den});
            rem_next[k]  = qbit_next[k] ? 32'(t - {1'b0, dv_pl_reg[k].den}) : t[31:0];
        end
    end

    always_comb
    begin
        fin   = dv_pl_reg[DIV_STEPS];
        de    = fin.ovf ? (DCAP_W'(1) << (DCAP_W - 1)) : DCAP_W'(dv_q_reg[DIV_STEPS]);
        e_sum = {{4{fin.kin.energy[31]}}, fin.kin.energy}
              + (fin.dneg ? (36'd0 - {2'b00, de}) : {2'b00, de});
        e_sat = (e_sum[35:31] != 5'b00000) && (e_sum[35:31] != 5'b11111);
        if (e_sat)
        begin
            e_next = e_sum[35] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        else
        begin
            e_next = e_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= in_item;
            s1_a_reg    <= {32'd0, dt} * {31'd0, in_item.rho_sum};

            s2_item_reg <= s1_item_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_plo_reg[i] <= {32'd0, s1_a_reg[31:0]} * {32'd0, s1_item_reg.gmag[i]};
                s2_phi_reg[i] <= {32'd0, s1_a_reg[62:32]} * {31'd0, s1_item_reg.gmag[i]};
            end

            s3_item_reg <= s2_item_reg;
            s3_dcap_reg <= dcap_next;

            s4_kin_reg <= kin_next;
            s4_mi_reg  <= mi_next;
            s4_mo_reg  <= mo_next;

            s5_kin_reg <= s4_kin_reg;
            for (int i = 0; i < 3; i++)
            begin
                s5_sqo_reg[i] <= {32'd0, s4_mi_reg[i]} * {32'd0, s4_mi_reg[i]};
                s5_sqn_reg[i] <= {32'd0, s4_mo_reg[i]} * {32'd0, s4_mo_reg[i]};
            end

            s6_kin_reg <= s5_kin_reg;
            s6_so_reg  <= s5_sqo_reg[0] + s5_sqo_reg[1] + s5_sqo_reg[2];
            s6_sn_reg  <= s5_sqn_reg[0] + s5_sqn_reg[1] + s5_sqn_reg[2];

            s7_kin_reg  <= s6_kin_reg;
            s7_dneg_reg <= (s6_sn_reg < s6_so_reg);
            s7_dmag_reg <= (s6_sn_reg < s6_so_reg) ? (s6_so_reg - s6_sn_reg)
                                                   : (s6_sn_reg - s6_so_reg);

            s8_kin_reg  <= s7_kin_reg;
            s8_dneg_reg <= s7_dneg_reg;
            s8_num_reg  <= {1'b0, s7_dmag_reg} + 65'(s7_kin_reg.rho_new);

            dv_pl_reg[0].kin  <= s8_kin_reg;
            dv_pl_reg[0].dneg <= s8_dneg_reg;
            dv_pl_reg[0].den  <= {s8_kin_reg.rho_new, 1'b0};
            dv_pl_reg[0].ovf  <= (s8_num_reg[64:33] >= {s8_kin_reg.rho_new, 1'b0});
            dv_rem_reg[0]     <= s8_num_reg[64:33];
            dv_num_reg[0]     <= s8_num_reg[32:0];
            dv_q_reg[0]       <= '0;

            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_pl_reg[k+1]  <= dv_pl_reg[k];
                dv_rem_reg[k+1] <= rem_next[k];
                dv_num_reg[k+1] <= {dv_num_reg[k][31:0], 1'b0};
                dv_q_reg[k+1]   <= {dv_q_reg[k][31:0], qbit_next[k]};
            end

            tag_reg <= fin.kin.tag;
            mom_reg <= fin.kin.mom;
            if (fin.kin.zero)
            begin
                energy_reg <= fin.kin.energy;
                status_reg <= ST_ZERO;
            end
            else
            begin
                energy_reg <= e_next;
                status_reg <= (fin.kin.sat || e_sat) ? ST_SAT : ST_OK;
            end
        end
    end

    assign cell_tag_out = tag_reg;
    assign mom_x_out    = mom_reg[0];
    assign mom_y_out    = mom_reg[1];
    assign mom_z_out    = mom_reg[2];
    assign energy_out   = energy_reg;
    assign status       = status_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && en) |=> v_reg[0])
        else $error("accepted cell did not enter the pipeline");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_ZERO))
        else $error("invalid status code");

endmodule

`default_nettype wire

### hw/rtl/gravity_source_correction.sv
// ----------------------------------------------------------------------------
// gravity_source_correction
// Per-cell gravity source-term corrector for a finite-volume Euler update.
// Path from input accept to result valid: front register, queue entry,
// 43-stage back pipeline with a 33-step restoring divider.
// Throughput: one cell per cycle; the back pipeline stalls as a whole on
// output back-pressure. Reset clears all valid state; three_dim resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_source_correction
    import gsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [TAG_BITS-1:0]  cell_tag,
    input  wire logic [30:0]          rho_old,
    input  wire logic [30:0]          rho_new,
    input  wire logic [31:0]          mom_x_in,
    input  wire logic [31:0]          mom_y_in,
    input  wire logic [31:0]          mom_z_in,
    input  wire logic [31:0]          energy_in,
    input  wire logic [31:0]          field_grav_x,
    input  wire logic [31:0]          field_grav_y,
    input  wire logic [31:0]          field_grav_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [TAG_BITS-1:0]       cell_tag_out,
    output logic [31:0]               mom_x_out,
    output logic [31:0]               mom_y_out,
    output logic [31:0]               mom_z_out,
    output logic [31:0]               energy_out,
    output logic [1:0]                status
);

    gsc_cfg_t  cfg_reg;
    logic      f_valid, f_ready, q_valid, q_ready;
    gsc_item_t f_item, q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{dt: '0, grav: '0, cell_grav: 1'b0, three_dim: 1'b1};
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_TIME_STEP: cfg_reg.dt        <= cfg_data[30:0];
                CFG_GRAV_X:    cfg_reg.grav[0]   <= cfg_data;
                CFG_GRAV_Y:    cfg_reg.grav[1]   <= cfg_data;
                CFG_GRAV_Z:    cfg_reg.grav[2]   <= cfg_data;
                CFG_CELL_GRAV: cfg_reg.cell_grav <= cfg_data[0];
                CFG_THREE_DIM: cfg_reg.three_dim <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    gsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cell_tag     (cell_tag),
        .rho_old      (rho_old),
        .rho_new      (rho_new),
        .mom_x_in     (mom_x_in),
        .mom_y_in     (mom_y_in),
        .mom_z_in     (mom_z_in),
        .energy_in    (energy_in),
        .field_grav_x (field_grav_x),
        .field_grav_y (field_grav_y),
        .field_grav_z (field_grav_z),
        .out_valid    (f_valid),
        .out_ready    (f_ready),
        .out_item     (f_item)
    );

    gsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    gsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dt           (cfg_reg.dt),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_item      (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_tag_out (cell_tag_out),
        .mom_x_out    (mom_x_out),
        .mom_y_out    (mom_y_out),
        .mom_z_out    (mom_z_out),
        .energy_out   (energy_out),
        .status       (status)
    );

endmodule

`default_nettype wire

### dv/gsc_checker.sv
// ----------------------------------------------------------------------------
// gsc_checker
// Watches the register port and both cell channels of the gravity corrector.
// It mirrors the registers, predicts the corrected cell for each accepted
// input, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_checker
    import gsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [TAG_BITS-1:0]  cell_tag,
    input  wire logic [30:0]          rho_old,
    input  wire logic [30:0]          rho_new,
    input  wire logic [31:0]          mom_x_in,
    input  wire logic [31:0]          mom_y_in,
    input  wire logic [31:0]          mom_z_in,
    input  wire logic [31:0]          energy_in,
    input  wire logic [31:0]          field_grav_x,
    input  wire logic [31:0]          field_grav_y,
    input  wire logic [31:0]          field_grav_z,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [TAG_BITS-1:0]  cell_tag_out,
    input  wire logic [31:0]          mom_x_out,
    input  wire logic [31:0]          mom_y_out,
    input  wire logic [31:0]          mom_z_out,
    input  wire logic [31:0]          energy_out,
    input  wire logic [1:0]           status,
    output int                        errors,
    output int                        pending,
    output int                        cells_done,
    output int                        sat_seen,
    output int                        zero_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam logic [63:0] STEP_CAP = 64'd1 << 40;

    typedef struct {
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         mom [3];
        logic [31:0]         energy;
        logic [1:0]          st;
    } corrected_cell_t;

    logic [30:0] dt_q;
    longint      grav_q [3];
    logic        cell_grav_q;
    logic        three_dim_q;
    corrected_cell_t corrected_q [$];

    function automatic longint clip32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic corrected_cell_t correct_cell(
        input logic [TAG_BITS-1:0] tag,
        input logic [30:0]         r_old,
        input logic [30:0]         r_new,
        input logic [31:0]         m0,
        input logic [31:0]         m1,
        input logic [31:0]         m2,
        input logic [31:0]         e_in,
        input logic [31:0]         f0,
        input logic [31:0]         f1,
        input logic [31:0]         f2
    );
        corrected_cell_t r;
        longint      m_in [3];
        longint      m_out [3];
        longint      g;
        longint      e_new;
        longint      sum;
        logic [31:0] mw [3];
        logic [31:0] fw [3];
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] sq_old;
        logic [63:0] sq_new;
        logic [63:0] dmag;
        logic [127:0] prod;
        logic        sat;
        int          ncomp;
        mw = '{m0, m1, m2};
        fw = '{f0, f1, f2};
        sat = 1'b0;
        sq_old = '0;
        sq_new = '0;
        for (int i = 0; i < 3; i++)
        begin
            m_in[i] = $signed(mw[i]);
            m_out[i] = m_in[i];
        end
        e_new = $signed(e_in);
        r.tag = tag;
        r.st = ST_OK;
        if (r_new == '0)
        begin
            r.st = ST_ZERO;
        end
        else
        begin
            a = 64'(dt_q) * (64'(r_old) + 64'(r_new));
            ncomp = three_dim_q ? 3 : 2;
            for (int i = 0; i < ncomp; i++)
            begin
                g = cell_grav_q ? longint'($signed(fw[i])) : grav_q[i];
                prod = (128'(a) * 128'(mag(g)) + (128'd1 << (ROUND_SH - 1))) >> ROUND_SH;
                q = (prod > 128'(STEP_CAP)) ? STEP_CAP : prod[63:0];
                sum = m_in[i] + ((g < 0) ? -longint'(q) : longint'(q));
                m_out[i] = clip32(sum);
                if (m_out[i] != sum)
                    sat = 1'b1;
                sq_old += mag(m_in[i]) * mag(m_in[i]);
                sq_new += mag(m_out[i]) * mag(m_out[i]);
            end
            dmag = (sq_new < sq_old) ? sq_old - sq_new : sq_new - sq_old;
            q = (dmag + 64'(r_new)) / (64'(r_new) * 2);
            if (q > STEP_CAP)
                q = STEP_CAP;
            sum = e_new + ((sq_new < sq_old) ? -longint'(q) : longint'(q));
            e_new = clip32(sum);
            if (e_new != sum)
                sat = 1'b1;
            r.st = sat ? ST_SAT : ST_OK;
        end
        for (int i = 0; i < 3; i++)
            r.mom[i] = m_out[i][31:0];
        r.energy = e_new[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        corrected_cell_t exp_c;
        if (!rst_n)
        begin
            dt_q = '0;
            grav_q = '{0, 0, 0};
            cell_grav_q = 1'b0;
            three_dim_q = 1'b1;
            corrected_q.delete();
            errors = 0;
            cells_done = 0;
            sat_seen = 0;
            zero_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (gsc_cfg_idx_t'(cfg_addr))
                    CFG_TIME_STEP: dt_q = cfg_data[30:0];
                    CFG_GRAV_X:    grav_q[0] = $signed(cfg_data);
                    CFG_GRAV_Y:    grav_q[1] = $signed(cfg_data);
                    CFG_GRAV_Z:    grav_q[2] = $signed(cfg_data);
                    CFG_CELL_GRAV: cell_grav_q = cfg_data[0];
                    CFG_THREE_DIM: three_dim_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                corrected_q.push_back(correct_cell(cell_tag, rho_old, rho_new,
                    mom_x_in, mom_y_in, mom_z_in, energy_in,
                    field_grav_x, field_grav_y, field_grav_z));
            if (out_valid && out_ready)
            begin
                cells_done++;
                if (status == ST_SAT)
                    sat_seen++;
                if (status == ST_ZERO)
                    zero_seen++;
                if (corrected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: tag %h", cell_tag_out);
                end
                else
                begin
                    exp_c = corrected_q.pop_front();
                    if (cell_tag_out !== exp_c.tag || mom_x_out !== exp_c.mom[0]
                        || mom_y_out !== exp_c.mom[1] || mom_z_out !== exp_c.mom[2]
                        || energy_out !== exp_c.energy || status !== exp_c.st)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("cell %h: expected %h %h %h e %h st %0d, got %h %h %h e %h st %0d",
                                exp_c.tag, exp_c.mom[0], exp_c.mom[1], exp_c.mom[2],
                                exp_c.energy, exp_c.st, mom_x_out, mom_y_out, mom_z_out,
                                energy_out, status);
                    end
                end
            end
        end
        pending = corrected_q.size();
    end

endmodule

`default_nettype wire

### dv/tb_gravity_source_correction.sv
// ----------------------------------------------------------------------------
// tb_gravity_source_correction
// Drives cells through the gravity corrector under several register settings
// (2D and 3D, constant and per-cell gravity, zero and full-scale time step),
// with random idling on both channels and one long output hold-off. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gravity_source_correction;
    timeunit 1ns;
    timeprecision 1ps;
    import gsc_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [TAG_BITS-1:0] tag;
        logic [30:0]         r_old;
        logic [30:0]         r_new;
        logic [31:0]         mom [3];
        logic [31:0]         energy;
        logic [31:0]         fgrav [3];
    } cell_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [TAG_BITS-1:0]  cell_tag;
    logic [30:0]          rho_old;
    logic [30:0]          rho_new;
    logic [31:0]          mom_x_in;
    logic [31:0]          mom_y_in;
    logic [31:0]          mom_z_in;
    logic [31:0]          energy_in;
    logic [31:0]          field_grav_x;
    logic [31:0]          field_grav_y;
    logic [31:0]          field_grav_z;
    logic                 out_valid;
    logic                 out_ready;
    logic [TAG_BITS-1:0]  cell_tag_out;
    logic [31:0]          mom_x_out;
    logic [31:0]          mom_y_out;
    logic [31:0]          mom_z_out;
    logic [31:0]          energy_out;
    logic [1:0]           status;

    int errors;
    int pending;
    int cells_done;
    int sat_seen;
    int zero_seen;
    int cells_sent;
    int settings_used;
    int stall_cycles;

    gravity_source_correction dut (.*);

    gsc_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] pick32();
        logic [31:0] v;
        if ($urandom_range(1) == 1)
            return $urandom;
        v = $urandom_range(0, 'h7FFFF);
        return ($urandom_range(1) == 1) ? -v : v;
    endfunction

    function automatic logic [30:0] pick_rho();
        case ($urandom_range(19))
            0:       return '0;
            1, 2:    return 31'h7FFF_FFFF - 31'($urandom_range(3));
            3, 4, 5: return 31'($urandom);
            default: return 31'($urandom_range(1, 'h80000));
        endcase
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        c.tag = TAG_BITS'($urandom);
        c.r_old = pick_rho();
        c.r_new = pick_rho();
        for (int i = 0; i < 3; i++)
        begin
            c.mom[i] = pick32();
            c.fgrav[i] = pick32();
        end
        c.energy = pick32();
        return c;
    endfunction

    function automatic cell_t directed_cell(input int k);
        cell_t c;
        c.tag = TAG_BITS'(k);
        c.r_old = 31'h0001_0000;
        c.r_new = 31'h0001_0000;
        c.mom = '{32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000};
        c.energy = 32'h0010_0000;
        c.fgrav = '{32'hFFF6_3333, 32'h0000_0000, 32'h0009_CCCD};
        case (k)
            0: c.mom = '{32'h0, 32'h0, 32'h0};
            1: c.r_new = '0;
            2:
            begin
                c.r_old = 31'h7FFF_FFFF;
                c.r_new = 31'h7FFF_FFFF;
                c.mom = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
            end
            3: c.mom = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            4:
            begin
                c.r_new = 31'd1;
                c.energy = 32'h7FFF_FFFF;
            end
            5:
            begin
                c.r_new = 31'd1;
                c.energy = 32'h8000_0000;
                c.mom = '{32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_0000};
            end
            6: c.tag = '1;
            7:
            begin
                c.r_old = '0;
                c.r_new = 31'h7FFF_FFFF;
                c.mom = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
                c.energy = 32'hFFFF_FFFF;
            end
            8: c.fgrav = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
            9: c.fgrav = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
            default: ;
        endcase
        return c;
    endfunction

    task automatic write_reg(input gsc_cfg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] dt, input logic [31:0] gx,
                                  input logic [31:0] gy, input logic [31:0] gz,
                                  input logic field, input logic three);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_GRAV_X, gx);
        write_reg(CFG_GRAV_Y, gy);
        write_reg(CFG_GRAV_Z, gz);
        write_reg(CFG_CELL_GRAV, {31'($urandom), field});
        write_reg(CFG_THREE_DIM, {31'($urandom), three});
        settings_used++;
        @(posedge clk);
    endtask

    task automatic send_cell(input cell_t c);
        logic ok;
        if (!(cells_sent >= 700 && cells_sent < 900) && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 28);
        end
        in_valid <= 1'b1;
        cell_tag <= c.tag;
        rho_old <= c.r_old;
        rho_new <= c.r_new;
        mom_x_in <= c.mom[0];
        mom_y_in <= c.mom[1];
        mom_z_in <= c.mom[2];
        energy_in <= c.energy;
        field_grav_x <= c.fgrav[0];
        field_grav_y <= c.fgrav[1];
        field_grav_z <= c.fgrav[2];
        do
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end
        while (!ok);
        cells_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off, one stretch with no stalls
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && cells_sent >= 500)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            if (cells_sent >= 700 && cells_sent < 900)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("gravity_source_correction: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] dt;
        stall_cycles = 0;
        cells_sent = 0;
        settings_used = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cell_tag = '0;
        rho_old = '0;
        rho_new = '0;
        mom_x_in = '0;
        mom_y_in = '0;
        mom_z_in = '0;
        energy_in = '0;
        field_grav_x = '0;
        field_grav_y = '0;
        field_grav_z = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero time step
        for (int k = 0; k < 3; k++)
            send_cell(directed_cell(k));
        drain();

        apply_settings(32'h0001_0000, 32'hFFF6_3333, 32'h0000_4000, 32'h7FFF_FFFF,
                       1'b0, 1'b1);
        for (int k = 0; k < 10; k++)
            send_cell(directed_cell(k));
        drain();

        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       1'b1, 1'b0);
        for (int k = 0; k < 10; k++)
            send_cell(directed_cell(k));
        for (int n = 0; n < 100; n++)
            send_cell(random_cell());
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(7))
                0:       dt = '0;
                1:       dt = 32'h7FFF_FFFF;
                2:       dt = $urandom;
                default: dt = $urandom_range(1, 'h20000);
            endcase
            apply_settings(dt, pick32(), pick32(), pick32(),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            for (int n = 0; n < 140; n++)
                send_cell(random_cell());
            drain();
        end

        $display("%0d cells checked over %0d register settings", cells_done, settings_used);
        $display("%0d saturated and %0d zero-density results", sat_seen, zero_seen);
        if (errors == 0)
            $display("gravity_source_correction: match");
        else
            $display("gravity_source_correction: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/gsc_pkg.sv
hw/rtl/gsc_front.sv
hw/rtl/gsc_queue.sv
hw/rtl/gsc_back.sv
hw/rtl/gravity_source_correction.sv
dv/gsc_checker.sv
dv/tb_gravity_source_correction.sv
